// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks, all clocked on clk_i and quiet while rst_ni is low.

`define RSV_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("check failed: expression not held");

`define RSV_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

`define RSV_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== design/rsv_pkg.sv =====
`timescale 1ns / 1ps

package rsv_pkg;

  // Largest number the table can hold
  localparam int unsigned MAX_N = 65535;
  localparam int unsigned DEPTH = MAX_N + 1;
  localparam int unsigned N_W   = $clog2(DEPTH);
  // Counters run one past the limit before the loop test fails
  localparam int unsigned J_W   = N_W + 1;

  localparam int unsigned NUM_W = 16;
  localparam int unsigned RAD_W = 16;

  localparam logic [NUM_W-1:0] LIMIT_RST = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QP_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FN_BUILD = 1'b0,
    FN_QUERY = 1'b1
  } rsv_func_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_BUILT   = 2'd1,
    ST_ABOVE_LIMIT = 2'd2
  } rsv_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SV_RD,
    S_SV_CHK,
    S_SV_MARK,
    S_RAD_RD,
    S_RAD_CHK,
    S_RAD_MUL,
    S_FIN
  } rsv_state_e;

  typedef struct packed {
    rsv_func_e         func;
    logic [NUM_W-1:0]  number;
  } rsv_req_t;

  typedef struct packed {
    logic [RAD_W-1:0]  value;
    rsv_status_e       status;
  } rsv_rsp_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    rsv_func_e         func;
    rsv_status_e       status;
    logic [NUM_W-1:0]  number;
  } rsv_job_t;

  // Table state the back end reports to the front end
  typedef struct packed {
    logic              built;
    logic [NUM_W-1:0]  built_limit;
    logic              build_done;
  } rsv_tbl_t;

endpackage

// ===== design/rsv_front.sv =====
`timescale 1ns / 1ps

module rsv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  rsv_pkg::rsv_req_t        req_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rsv_pkg::NUM_W-1:0] cfg_data_i,
  input  rsv_pkg::rsv_tbl_t        tbl_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output rsv_pkg::rsv_job_t        job_o,
  output logic [rsv_pkg::NUM_W-1:0] limit_o
);

  logic [rsv_pkg::NUM_W-1:0] limit_q;
  logic                      build_pend_q, build_pend_d;

  assign cfg_ready_o = 1'b1;

  // Hold off new items while the queue is full or a taken build is not done
  assign busy   = build_pend_q | q_full_i;
  assign push_o = start & ~busy;

  always_comb begin
    job_o.func   = req_i.func;
    job_o.number = req_i.number;
    job_o.status = rsv_pkg::ST_OK;
    if (req_i.func == rsv_pkg::FN_QUERY) begin
      if (!tbl_i.built) begin
        job_o.status = rsv_pkg::ST_NOT_BUILT;
      end else if (req_i.number > tbl_i.built_limit) begin
        job_o.status = rsv_pkg::ST_ABOVE_LIMIT;
      end
    end
  end

  always_comb begin
    build_pend_d = build_pend_q;
    if (tbl_i.build_done) begin
      build_pend_d = 1'b0;
    end
    if (push_o && req_i.func == rsv_pkg::FN_BUILD) begin
      build_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= rsv_pkg::LIMIT_RST;
      build_pend_q <= 1'b0;
    end else begin
      build_pend_q <= build_pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign limit_o = limit_q;

endmodule

// ===== design/rsv_queue.sv =====
`timescale 1ns / 1ps

module rsv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsv_pkg::rsv_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rsv_pkg::rsv_job_t job_o
);

  rsv_pkg::rsv_job_t           entry_q [rsv_pkg::QUEUE_DEPTH];
  logic [rsv_pkg::QP_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rsv_pkg::QC_W-1:0]    count_q;
  logic                        do_push, do_pop;

  assign full_o  = (count_q == rsv_pkg::QC_W'(rsv_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rsv_pkg::QP_W'(rsv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rsv_pkg::QP_W'(rsv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/rsv_back.sv =====
`timescale 1ns / 1ps

module rsv_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  rsv_pkg::rsv_job_t         job_i,
  output logic                      job_pop_o,
  input  logic [rsv_pkg::NUM_W-1:0] limit_i,
  output rsv_pkg::rsv_tbl_t         tbl_o,
  output logic                      res_valid_o,
  output rsv_pkg::rsv_rsp_t         rsp_o
);

  localparam int unsigned N_W   = rsv_pkg::N_W;
  localparam int unsigned J_W   = rsv_pkg::J_W;
  localparam int unsigned RAD_W = rsv_pkg::RAD_W;

  // Prime marks and radical table, both written before being read
  logic             mark_mem [rsv_pkg::DEPTH];
  logic [RAD_W-1:0] rad_mem  [rsv_pkg::DEPTH];

  rsv_pkg::rsv_state_e state_q, state_d;

  logic [N_W-1:0]   lim_q, lim_d, lim_eff;
  logic [J_W-1:0]   i_q, i_d, j_q, j_d, sq_q, sq_d, lim_x, sq_step;

  logic             mark_we, mark_wdata, mark_re, mark_rdata_q;
  logic [N_W-1:0]   mark_waddr, mark_raddr;

  logic             rad_re, init_we, rad_we, rd_mul;
  logic [N_W-1:0]   rad_raddr, rad_waddr;
  logic [RAD_W-1:0] rad_wdata, rad_rdata_q, prod;

  logic             mul_vld_q;
  logic [N_W-1:0]   wr_addr_q;
  logic [RAD_W-1:0] wr_i_q;

  logic                 res_vld_q, res_vld_d, res_mem_q, res_mem_d, fin;
  rsv_pkg::rsv_status_e res_status_q, res_status_d;
  logic                 built_q;
  logic [rsv_pkg::NUM_W-1:0] built_limit_q;

  assign lim_eff = (32'(limit_i) > rsv_pkg::MAX_N) ? N_W'(rsv_pkg::MAX_N) : N_W'(limit_i);
  assign lim_x   = J_W'(lim_q);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_step = sq_q + J_W'({i_q, 1'b0}) + J_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsv_pkg::S_IDLE: begin
        if (job_valid_i && job_i.func == rsv_pkg::FN_BUILD) begin
          state_d = rsv_pkg::S_INIT;
        end
      end
      rsv_pkg::S_INIT: begin
        if (i_q == lim_x) begin
          state_d = rsv_pkg::S_SV_RD;
        end
      end
      rsv_pkg::S_SV_RD: begin
        state_d = (sq_q > lim_x) ? rsv_pkg::S_RAD_RD : rsv_pkg::S_SV_CHK;
      end
      rsv_pkg::S_SV_CHK: begin
        state_d = mark_rdata_q ? rsv_pkg::S_SV_MARK : rsv_pkg::S_SV_RD;
      end
      rsv_pkg::S_SV_MARK: begin
        if (j_q > lim_x) begin
          state_d = rsv_pkg::S_SV_RD;
        end
      end
      rsv_pkg::S_RAD_RD: begin
        state_d = (i_q > lim_x) ? rsv_pkg::S_FIN : rsv_pkg::S_RAD_CHK;
      end
      rsv_pkg::S_RAD_CHK: begin
        state_d = mark_rdata_q ? rsv_pkg::S_RAD_MUL : rsv_pkg::S_RAD_RD;
      end
      rsv_pkg::S_RAD_MUL: begin
        if (j_q > lim_x) begin
          state_d = rsv_pkg::S_RAD_RD;
        end
      end
      rsv_pkg::S_FIN: begin
        state_d = rsv_pkg::S_IDLE;
      end
      default: begin
        state_d = rsv_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    job_pop_o    = 1'b0;
    lim_d        = lim_q;
    i_d          = i_q;
    j_d          = j_q;
    sq_d         = sq_q;
    mark_we      = 1'b0;
    mark_waddr   = i_q[N_W-1:0];
    mark_wdata   = 1'b0;
    mark_re      = 1'b0;
    mark_raddr   = i_q[N_W-1:0];
    rad_re       = 1'b0;
    rad_raddr    = j_q[N_W-1:0];
    rd_mul       = 1'b0;
    init_we      = 1'b0;
    res_vld_d    = 1'b0;
    res_status_d = rsv_pkg::ST_OK;
    res_mem_d    = 1'b0;
    fin          = 1'b0;
    case (state_q)
      rsv_pkg::S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.func == rsv_pkg::FN_BUILD) begin
            lim_d = lim_eff;
            i_d   = '0;
          end else begin
            res_vld_d    = 1'b1;
            res_status_d = job_i.status;
            if (job_i.status == rsv_pkg::ST_OK) begin
              rad_re    = 1'b1;
              rad_raddr = N_W'(job_i.number);
              res_mem_d = 1'b1;
            end
          end
        end
      end
      rsv_pkg::S_INIT: begin
        // Entries 0 to the limit start at rad = 1, marks set from 2 upwards
        mark_we    = 1'b1;
        mark_wdata = (i_q >= J_W'(2));
        init_we    = 1'b1;
        if (i_q == lim_x) begin
          i_d  = J_W'(2);
          sq_d = J_W'(4);
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      rsv_pkg::S_SV_RD: begin
        if (sq_q > lim_x) begin
          i_d = J_W'(2);
        end else begin
          mark_re = 1'b1;
        end
      end
      rsv_pkg::S_SV_CHK: begin
        if (mark_rdata_q) begin
          j_d = sq_q;
        end else begin
          sq_d = sq_step;
          i_d  = i_q + 1'b1;
        end
      end
      rsv_pkg::S_SV_MARK: begin
        if (j_q > lim_x) begin
          sq_d = sq_step;
          i_d  = i_q + 1'b1;
        end else begin
          mark_we    = 1'b1;
          mark_waddr = j_q[N_W-1:0];
          j_d        = j_q + i_q;
        end
      end
      rsv_pkg::S_RAD_RD: begin
        if (i_q <= lim_x) begin
          mark_re = 1'b1;
        end
      end
      rsv_pkg::S_RAD_CHK: begin
        if (mark_rdata_q) begin
          j_d = i_q;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      rsv_pkg::S_RAD_MUL: begin
        // One read per cycle; multiply and write-back follow in the next cycle
        if (j_q > lim_x) begin
          i_d = i_q + 1'b1;
        end else begin
          rad_re = 1'b1;
          rd_mul = 1'b1;
          j_d    = j_q + i_q;
        end
      end
      rsv_pkg::S_FIN: begin
        fin       = 1'b1;
        res_vld_d = 1'b1;
      end
      default: begin
        job_pop_o = 1'b0;
      end
    endcase
  end

  assign prod      = RAD_W'(rad_rdata_q * wr_i_q);
  assign rad_we    = init_we | mul_vld_q;
  assign rad_waddr = mul_vld_q ? wr_addr_q : i_q[N_W-1:0];
  assign rad_wdata = mul_vld_q ? prod : RAD_W'(1);

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (mark_re) begin
      mark_rdata_q <= mark_mem[mark_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rad_we) begin
      rad_mem[rad_waddr] <= rad_wdata;
    end
    if (rad_re) begin
      rad_rdata_q <= rad_mem[rad_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q        <= lim_d;
    i_q          <= i_d;
    j_q          <= j_d;
    sq_q         <= sq_d;
    wr_addr_q    <= j_q[N_W-1:0];
    wr_i_q       <= RAD_W'(i_q);
    res_status_q <= res_status_d;
    res_mem_q    <= res_mem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rsv_pkg::S_IDLE;
      mul_vld_q     <= 1'b0;
      res_vld_q     <= 1'b0;
      built_q       <= 1'b0;
      built_limit_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_vld_q <= rd_mul;
      res_vld_q <= res_vld_d;
      if (fin) begin
        built_q       <= 1'b1;
        built_limit_q <= rsv_pkg::NUM_W'(lim_q);
      end
    end
  end

  assign tbl_o.built       = built_q;
  assign tbl_o.built_limit = built_limit_q;
  assign tbl_o.build_done  = fin;

  assign res_valid_o  = res_vld_q;
  assign rsp_o.value  = res_mem_q ? rad_rdata_q : '0;
  assign rsp_o.status = res_status_q;

endmodule

// ===== design/radical_sieve_table.sv =====
`timescale 1ns / 1ps

// Channel   Signals                              Transfer
// ------------------------------------------------------------------------------
// item      start, busy, req_i                   start & !busy at a rising edge
// result    res_valid_o, rsp_o                   one cycle per strobe, no back-pressure
// config    cfg_valid_i, cfg_ready_o, cfg_data_i cfg_valid_i & cfg_ready_o (ready always high)
//
// Queries sustain one per cycle while no build is pending; each query is registered in the
// item queue, then its radical read and result strobe are registered in the back end.
// A build holds busy high while the sieve sequencer walks the mark and radical memories,
// at most one read and one write each per cycle: it sets every entry up to L (L = limit),
// marks multiples of primes p<=sqrt(L), then multiplies each prime p<=L into its multiples.
// Reset clears control and the built flag; the tables need no clearing pass.
// busy also rises when the two-entry item queue is full.

module radical_sieve_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rsv_pkg::rsv_req_t         req_i,
  output logic                      res_valid_o,
  output rsv_pkg::rsv_rsp_t         rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rsv_pkg::NUM_W-1:0] cfg_data_i
);

  rsv_pkg::rsv_tbl_t         tbl;
  rsv_pkg::rsv_job_t         push_job, pop_job;
  logic                      push, q_full, q_valid, pop;
  logic [rsv_pkg::NUM_W-1:0] limit;

  rsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .tbl_i       (tbl),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job),
    .limit_o     (limit)
  );

  rsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  rsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .limit_i     (limit),
    .tbl_o       (tbl),
    .res_valid_o (res_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== design/rsv_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rsv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input rsv_pkg::rsv_req_t         req_i,
  input logic                      res_valid_o,
  input rsv_pkg::rsv_rsp_t         rsp_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [rsv_pkg::NUM_W-1:0] cfg_data_i
);

  logic build_xfer;
  logic cfg_xfer;

  assign build_xfer = start && !busy && req_i.func == rsv_pkg::FN_BUILD;
  assign cfg_xfer   = cfg_valid_i && cfg_ready_o && (cfg_data_i == cfg_data_i);

  // A build locks out further items at least for the following cycle
  `RSV_NEXT(a_build_locks, build_xfer, busy)

  // Error results carry no radical
  `RSV_IMPLIES(a_err_zero, res_valid_o && rsp_o.status != rsv_pkg::ST_OK, rsp_o.value == '0)

  // Nothing comes out in the first cycle after reset
  `RSV_IMPLIES(a_quiet_after_rst, $rose(rst_ni), !res_valid_o)

  // Configuration writes are never held off
  `RSV_IMPLIES(a_cfg_taken, cfg_valid_i, cfg_xfer)

endmodule

bind radical_sieve_table rsv_checker u_chk (.*);
